[hw/rtl/hmt_pkg.sv]
// ----------------------------------------------------------------------------
// hmt_pkg: shared types and constants of the header template matcher
// Holds the configuration record, the queue entry between the front and back
// parts, the register indexes, the match mode codes and the header offsets.
// ----------------------------------------------------------------------------
package hmt_pkg;

    localparam int HMT_TEMPLATE_BYTES = 128;

    // Queue between the front and back parts.
    localparam int HMT_QDEPTH = 4;
    localparam int HMT_QPW    = $clog2(HMT_QDEPTH);
    localparam int HMT_QCW    = $clog2(HMT_QDEPTH + 1);

    // Configuration port.
    localparam int HMT_CFG_IW = 3;
    localparam int HMT_CFG_DW = 7;

    // Width used for frame offset arithmetic (offsets plus lengths reach 254).
    localparam int HMT_OW = 9;

    typedef enum logic [HMT_CFG_IW-1:0] {
        CFG_MATCH_MODE = 3'd0,
        CFG_L2_LENGTH  = 3'd1,
        CFG_UDP_OFFSET = 3'd2,
        CFG_L3_OFFSET  = 3'd3,
        CFG_L3_LENGTH  = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        MODE_ALWAYS    = 3'd0,
        MODE_ETH_UCAST = 3'd1,
        MODE_ETH_MCAST = 3'd2,
        MODE_UDP       = 3'd3,
        MODE_VXLAN     = 3'd4
    } t_match_mode;

    localparam logic OP_TPL_WRITE  = 1'b0;
    localparam logic OP_FRAME_BYTE = 1'b1;

    localparam logic [4:0]  VLAN_L2_LENGTH = 5'd18;
    localparam logic [4:0]  ETH_L2_LENGTH  = 5'd14;
    localparam logic [11:0] TCI_VID_MASK   = 12'h0FFF;
    localparam logic [7:0]  BYTE_MASK      = 8'hFF;
    localparam logic [7:0]  VID_HI_MASK    = {4'h0, TCI_VID_MASK[11:8] & BYTE_MASK[3:0]};
    localparam logic [7:0]  POS_MAX        = 8'd255;

    // Outer Ethernet and VLAN header offsets.
    localparam logic [HMT_OW-1:0] ETH_HDR_BYTES = 9'd14;
    localparam logic [HMT_OW-1:0] ETH_TYPE_OFS  = 9'd12;
    localparam logic [HMT_OW-1:0] ETH_TYPE_END  = 9'd13;
    localparam logic [HMT_OW-1:0] VLAN_TCI_OFS  = 9'd14;
    localparam logic [HMT_OW-1:0] VLAN_TCI_LO   = 9'd15;
    localparam logic [HMT_OW-1:0] VLAN_HDR_END  = 9'd17;
    localparam logic [HMT_OW-1:0] ETH_HDR_END   = 9'd13;

    // VXLAN offsets relative to the outer UDP header.
    localparam logic [HMT_OW-1:0] VX_DPORT_OFS = 9'd2;
    localparam logic [HMT_OW-1:0] VX_DPORT_END = 9'd4;
    localparam logic [HMT_OW-1:0] VX_VNI_OFS   = 9'd12;
    localparam logic [HMT_OW-1:0] VX_RSVD_OFS  = 9'd15;
    localparam logic [HMT_OW-1:0] VX_INNER_OFS = 9'd16;
    localparam logic [HMT_OW-1:0] VX_END_OFS   = 9'd30;
    localparam logic [HMT_OW-1:0] VX_LAST_OFS  = 9'd29;

    typedef struct packed {
        logic [2:0] match_mode;
        logic [4:0] l2_length;
        logic [6:0] udp_offset;
        logic [6:0] l3_match_offset;
        logic [6:0] l3_match_length;
    } t_hmt_cfg;

    // Which comparisons apply to one frame byte.
    typedef struct packed {
        logic chk_full;
        logic chk_vid;
        logic chk_zero;
        logic chk_mcast;
    } t_hmt_checks;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  tpl;
        t_hmt_checks checks;
        logic        last;
        logic        short_frame;
    } t_hmt_entry;

    typedef struct packed {
        logic       valid;
        t_hmt_entry entry;
    } t_hmt_slot;

endpackage

[hw/rtl/hmt_in_if.sv]
// ----------------------------------------------------------------------------
// hmt_in_if: input channel of the header template matcher
// Carries template writes and received frame bytes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hmt_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [6:0] position;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, op, position, data_byte, last, input ready);
    modport sink   (input valid, op, position, data_byte, last, output ready);
endinterface

[hw/rtl/hmt_out_if.sv]
// ----------------------------------------------------------------------------
// hmt_out_if: result channel of the header template matcher
// Carries one match verdict per frame with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hmt_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic frame_short;

    modport source (output valid, matched, frame_short, input ready);
    modport sink   (input valid, matched, frame_short, output ready);
endinterface

[hw/rtl/rx_header_template_matcher.sv]
// ----------------------------------------------------------------------------
// rx_header_template_matcher: received frame header template matcher
// Checks the headers of a received frame, byte by byte, against a stored
// template under one of several Ethernet, UDP and VXLAN match modes.
// ----------------------------------------------------------------------------
// Usage. Items enter on i_item. An item with op clear writes data_byte into the
// template at position; an item with op set is the next byte of a frame, and
// last marks the final byte. Each frame yields exactly one item on o_result,
// carrying matched and frame_short. Template writes yield nothing.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data while no frame is in progress; writes to unknown indexes are
// dropped.
// Throughput is one item per cycle while i_item.ready is high. The front part
// takes a byte, reads its template byte from the single-port template memory
// and classifies it; a four-entry queue then feeds the back part, which
// compares and keeps the sticky mismatch flag. The last byte of a frame passes
// through the front register and the queue before its verdict is registered.
// When the receiver stalls o_result, the back part keeps draining non-final
// bytes; i_item.ready drops only once the queue, counting the byte still
// being classified, is full.
// Reset clears the frame offset, the mismatch flag, the queue and the
// configuration registers; the template itself is not cleared and must be
// written before use.
// ----------------------------------------------------------------------------
module rx_header_template_matcher #(
    parameter int TEMPLATE_BYTES = hmt_pkg::HMT_TEMPLATE_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hmt_in_if.sink                           i_item,
    hmt_out_if.source                        o_result,
    input  logic                             i_cfg_we,
    input  logic [hmt_pkg::HMT_CFG_IW-1:0]   i_cfg_index,
    input  logic [hmt_pkg::HMT_CFG_DW-1:0]   i_cfg_data
);
    import hmt_pkg::*;

    t_hmt_cfg            r_cfg;
    t_hmt_slot           w_push;
    t_hmt_slot           w_head;
    logic                w_pop;
    logic [HMT_QCW-1:0]  w_qcount;

    // Configuration registers. Changes take effect from the next frame byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_mode      <= MODE_ALWAYS;
            r_cfg.l2_length       <= ETH_L2_LENGTH;
            r_cfg.udp_offset      <= '0;
            r_cfg.l3_match_offset <= '0;
            r_cfg.l3_match_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATCH_MODE: begin
                    r_cfg.match_mode <= i_cfg_data[2:0];
                end
                CFG_L2_LENGTH: begin
                    r_cfg.l2_length <= i_cfg_data[4:0];
                end
                CFG_UDP_OFFSET: begin
                    r_cfg.udp_offset <= i_cfg_data;
                end
                CFG_L3_OFFSET: begin
                    r_cfg.l3_match_offset <= i_cfg_data;
                end
                CFG_L3_LENGTH: begin
                    r_cfg.l3_match_length <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Front part: template memory, frame offset and per-byte classification.
    hmt_front #(
        .TEMPLATE_BYTES (TEMPLATE_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_qcount (w_qcount),
        .o_push   (w_push)
    );

    // Queue decoupling classification from comparison.
    hmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_qcount)
    );

    // Back part: comparison, sticky mismatch and the result register.
    hmt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // The front part never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (w_qcount != HMT_QCW'(HMT_QDEPTH)))
        else $error("queue overflow");

    // A final byte leaves the queue only when the result register can take it.
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_head.entry.last) |-> (!o_result.valid || o_result.ready))
        else $error("result overwritten while stalled");

    // A short frame never reports a match.
    a_short_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.matched && o_result.frame_short))
        else $error("short frame reported as matched");
`endif

endmodule

[hw/rtl/hmt_front.sv]
// ----------------------------------------------------------------------------
// hmt_front: accepting and classifying part of the template matcher
// Owns the template memory and the frame offset counter, decides which checks
// apply to each frame byte and hands it, with its template byte, to the queue.
// ----------------------------------------------------------------------------
module hmt_front #(
    parameter int TEMPLATE_BYTES = hmt_pkg::HMT_TEMPLATE_BYTES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    hmt_in_if.sink                       i_item,
    input  hmt_pkg::t_hmt_cfg            i_cfg,
    input  logic [hmt_pkg::HMT_QCW-1:0]  i_qcount,
    output hmt_pkg::t_hmt_slot           o_push
);
    import hmt_pkg::*;

    localparam int AW = $clog2(TEMPLATE_BYTES);
    localparam logic [HMT_OW-1:0] DEPTH_W = HMT_OW'(TEMPLATE_BYTES);

    logic [7:0]          r_mem [TEMPLATE_BYTES];
    logic [7:0]          r_pos;
    logic [7:0]          n_pos;
    logic                r_s1_valid;
    logic [7:0]          r_s1_byte;
    t_hmt_checks         r_s1_checks;
    logic                r_s1_last;
    logic                r_s1_short;
    logic                r_s1_oob;
    logic [7:0]          r_tpl;

    logic [HMT_QCW:0]    w_used;
    logic                w_ready;
    logic                w_wr;
    logic                w_fb;
    logic [HMT_OW-1:0]   w_p;
    logic [HMT_OW-1:0]   w_u;
    logic [HMT_OW-1:0]   w_l3_lo;
    logic [HMT_OW-1:0]   w_l3_hi;
    logic                w_chk_mode;
    logic                w_mcast;
    logic                w_l3;
    logic                w_vx;
    logic                w_vlan;
    logic                w_in_l3;
    logic                w_in_vx;
    logic                w_short;
    t_hmt_checks         w_checks;

    // Room is counted conservatively: queue fill plus the byte in flight.
    assign w_used  = {1'b0, i_qcount} + {{HMT_QCW{1'b0}}, r_s1_valid};
    assign w_ready = w_used < (HMT_QCW + 1)'(HMT_QDEPTH);
    assign i_item.ready = w_ready;

    assign w_wr = i_item.valid && w_ready && (i_item.op == OP_TPL_WRITE);
    assign w_fb = i_item.valid && w_ready && (i_item.op == OP_FRAME_BYTE);

    assign w_p     = {1'b0, r_pos};
    assign w_u     = HMT_OW'(i_cfg.udp_offset);
    assign w_l3_lo = HMT_OW'(i_cfg.l3_match_offset);
    assign w_l3_hi = w_l3_lo + HMT_OW'(i_cfg.l3_match_length);

    assign w_mcast    = i_cfg.match_mode == MODE_ETH_MCAST;
    assign w_vx       = i_cfg.match_mode == MODE_VXLAN;
    assign w_l3       = (i_cfg.match_mode == MODE_UDP) || w_vx;
    assign w_chk_mode = (i_cfg.match_mode == MODE_ETH_UCAST) || w_mcast || w_l3;
    assign w_vlan     = i_cfg.l2_length == VLAN_L2_LENGTH;

    assign w_in_l3 = (w_p >= w_l3_lo) && (w_p < w_l3_hi);
    assign w_in_vx = ((w_p >= w_u + VX_DPORT_OFS) && (w_p < w_u + VX_DPORT_END))
                  || ((w_p >= w_u + VX_VNI_OFS) && (w_p < w_u + VX_RSVD_OFS))
                  || ((w_p >= w_u + VX_INNER_OFS) && (w_p < w_u + VX_END_OFS));

    always_comb begin
        w_checks.chk_full = w_chk_mode && (
              (!w_mcast && (w_p < ETH_HDR_BYTES))
            || (w_mcast && ((w_p == ETH_TYPE_OFS) || (w_p == ETH_TYPE_END)))
            || (w_vlan && (w_p >= VLAN_TCI_LO) && (w_p <= VLAN_HDR_END))
            || (w_l3 && w_in_l3)
            || (w_vx && w_in_vx));
        w_checks.chk_vid   = w_chk_mode && w_vlan && (w_p == VLAN_TCI_OFS);
        w_checks.chk_zero  = w_vx && (w_p == w_u + VX_RSVD_OFS);
        w_checks.chk_mcast = w_mcast && (w_p == '0);
    end

    // The frame is short if this byte lies below the last offset any check needs.
    assign w_short = w_chk_mode && (
          (w_p < (w_vlan ? VLAN_HDR_END : ETH_HDR_END))
        || (w_l3 && (i_cfg.l3_match_length != '0) && (w_p + 9'd1 < w_l3_hi))
        || (w_vx && (w_p < w_u + VX_LAST_OFS)));

    always_comb begin
        n_pos = r_pos;
        if (w_fb) begin
            if (i_item.last) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_s1_valid <= w_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr && ({2'b0, i_item.position} < DEPTH_W)) begin
            r_mem[AW'(i_item.position)] <= i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fb) begin
            r_tpl       <= r_mem[AW'(r_pos)];
            r_s1_oob    <= w_p >= DEPTH_W;
            r_s1_byte   <= i_item.data_byte;
            r_s1_checks <= w_checks;
            r_s1_last   <= i_item.last;
            r_s1_short  <= w_short;
        end
    end

    always_comb begin
        o_push.valid             = r_s1_valid;
        o_push.entry.data_byte   = r_s1_byte;
        o_push.entry.tpl         = r_s1_oob ? 8'd0 : r_tpl;
        o_push.entry.checks      = r_s1_checks;
        o_push.entry.last        = r_s1_last;
        o_push.entry.short_frame = r_s1_short;
    end

endmodule

[hw/rtl/hmt_queue.sv]
// ----------------------------------------------------------------------------
// hmt_queue: short queue between the front and back parts
// A small register FIFO of classified frame bytes.
// ----------------------------------------------------------------------------
module hmt_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hmt_pkg::t_hmt_slot           i_push,
    input  logic                         i_pop,
    output hmt_pkg::t_hmt_slot           o_head,
    output logic [hmt_pkg::HMT_QCW-1:0]  o_count
);
    import hmt_pkg::*;

    t_hmt_entry          r_ent [HMT_QDEPTH];
    logic [HMT_QPW-1:0]  r_wptr;
    logic [HMT_QPW-1:0]  r_rptr;
    logic [HMT_QCW-1:0]  r_count;
    logic [HMT_QCW-1:0]  n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + HMT_QCW'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - HMT_QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wptr <= r_wptr + HMT_QPW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + HMT_QPW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_ent[r_wptr] <= i_push.entry;
        end
    end

    assign o_head.valid = r_count != '0;
    assign o_head.entry = r_ent[r_rptr];
    assign o_count      = r_count;

endmodule

[hw/rtl/hmt_back.sv]
// ----------------------------------------------------------------------------
// hmt_back: comparing part of the template matcher
// Compares each queued frame byte with its template byte, keeps the sticky
// mismatch flag and registers one verdict at the end of each frame.
// ----------------------------------------------------------------------------
module hmt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hmt_pkg::t_hmt_slot  i_head,
    output logic                o_pop,
    hmt_out_if.source           o_result
);
    import hmt_pkg::*;

    logic        r_mismatch;
    logic        r_out_valid;
    logic        r_matched;
    logic        r_short;
    logic        w_slot_free;
    logic        w_ok;
    t_hmt_entry  w_e;

    assign w_e         = i_head.entry;
    assign w_slot_free = !r_out_valid || o_result.ready;
    assign o_pop       = i_head.valid && (!w_e.last || w_slot_free);

    always_comb begin
        w_ok = 1'b1;
        if (w_e.checks.chk_full && (w_e.data_byte != w_e.tpl)) begin
            w_ok = 1'b0;
        end
        if (w_e.checks.chk_vid && ((w_e.data_byte & VID_HI_MASK) != w_e.tpl)) begin
            w_ok = 1'b0;
        end
        // The reserved byte is masked to zero, so only a zero template passes.
        if (w_e.checks.chk_zero && (w_e.tpl != 8'd0)) begin
            w_ok = 1'b0;
        end
        if (w_e.checks.chk_mcast && !w_e.data_byte[0]) begin
            w_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mismatch  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && w_e.last) begin
                r_out_valid <= 1'b1;
                r_mismatch  <= 1'b0;
            end else begin
                if (o_result.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (o_pop && !w_ok) begin
                    r_mismatch <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_e.last) begin
            r_short   <= w_e.short_frame;
            r_matched <= !w_e.short_frame && !r_mismatch && w_ok;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.matched     = r_matched;
    assign o_result.frame_short = r_short;

endmodule

[test/rx_header_template_matcher_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_header_template_matcher_test: self-checking bench of the header matcher
// Loads the whole template, walks a short table of hand-picked frames and
// register settings, then streams random frames under many match modes. Every
// verdict is compared with a verdict worked out in the bench or typed into the table.
// ----------------------------------------------------------------------------
module rx_header_template_matcher_test;

    import hmt_pkg::*;

    // Match mode codes outside the defined set; they must behave as always.
    localparam logic [2:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    // Cycles allowed for the pipeline to drain once no verdict is pending.
    localparam int SETTLE_CYCLES = 16;

    localparam int RANDOM_ITEMS  = 1300;
    localparam int RANDOM_FRAMES = 60;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic       op;
        logic [6:0] position;
        logic [7:0] data_byte;
        logic       last;
    } hdr_item_t;

    typedef struct packed {
        logic matched;
        logic frame_short;
    } verdict_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        t_hmt_cfg  cfg;
        hdr_item_t item;
        logic      typed;
        verdict_t  want;
    } row_t;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [HMT_CFG_IW-1:0] cfg_index;
    logic [HMT_CFG_DW-1:0] cfg_data;

    hmt_in_if  item_ch();
    hmt_out_if result_ch();

    rx_header_template_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow of the block: template contents, register settings, frame state.
    logic [7:0] tpl_shadow [HMT_TEMPLATE_BYTES];
    t_hmt_cfg   shadow_cfg;
    int         frame_ofs;
    bit         frame_bad;

    verdict_t pending_verdicts [$];
    row_t     directed_rows [$];

    int error_count;
    int items_sent;
    int frames_done;
    int long_frames;
    int send_idle;
    int recv_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("rx_header_template_matcher_test: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Verdict prediction
    // ------------------------------------------------------------------------

    // Offsets beyond the template compare against zero.
    function automatic logic [7:0] tpl_byte(input int p);
        if (p < HMT_TEMPLATE_BYTES) begin
            return tpl_shadow[p];
        end
        return 8'h00;
    endfunction

    function automatic bit mode_compares();
        return shadow_cfg.match_mode >= MODE_ETH_UCAST && shadow_cfg.match_mode <= MODE_VXLAN;
    endfunction

    // Highest frame offset the current mode looks at, or -1 when it needs none.
    function automatic int last_needed_ofs();
        int r;
        int e;
        if (!mode_compares()) begin
            return -1;
        end
        r = (shadow_cfg.l2_length == VLAN_L2_LENGTH) ? 17 : 13;
        if (shadow_cfg.match_mode >= MODE_UDP && shadow_cfg.l3_match_length != 7'd0) begin
            e = int'(shadow_cfg.l3_match_offset) + int'(shadow_cfg.l3_match_length) - 1;
            if (e > r) begin
                r = e;
            end
        end
        if (shadow_cfg.match_mode == MODE_VXLAN) begin
            e = int'(shadow_cfg.udp_offset) + 29;
            if (e > r) begin
                r = e;
            end
        end
        return r;
    endfunction

    // True when frame byte b at offset p passes every check that covers it.
    function automatic bit byte_passes(input int p, input logic [7:0] b);
        logic [7:0] t;
        int         u;
        int         lo;
        int         hi;
        bit         ok;
        t  = tpl_byte(p);
        u  = int'(shadow_cfg.udp_offset);
        lo = int'(shadow_cfg.l3_match_offset);
        hi = lo + int'(shadow_cfg.l3_match_length);
        ok = 1'b1;
        if (!mode_compares()) begin
            return 1'b1;
        end
        if (shadow_cfg.match_mode == MODE_ETH_MCAST) begin
            // Multicast only needs the group bit and the type field.
            if (p == 0 && b[0] == 1'b0) ok = 1'b0;
            if ((p == 12 || p == 13) && b != t) ok = 1'b0;
        end else if (p < 14 && b != t) begin
            ok = 1'b0;
        end
        if (shadow_cfg.l2_length == VLAN_L2_LENGTH) begin
            // The upper TCI byte only contributes its VID nibble.
            if (p == 14 && (b & VID_HI_MASK) != t) ok = 1'b0;
            if (p >= 15 && p <= 17 && b != t) ok = 1'b0;
        end
        if (shadow_cfg.match_mode >= MODE_UDP && p >= lo && p < hi && b != t) ok = 1'b0;
        if (shadow_cfg.match_mode == MODE_VXLAN) begin
            if (p >= u + 2 && p < u + 4 && b != t) ok = 1'b0;
            if (p >= u + 12 && p < u + 15 && b != t) ok = 1'b0;
            // The reserved byte is masked away, so only a zero template passes.
            if (p == u + 15 && t != 8'h00) ok = 1'b0;
            if (p >= u + 16 && p < u + 30 && b != t) ok = 1'b0;
        end
        return ok;
    endfunction

    // Folds one accepted item into the shadow; a final frame byte gives a verdict.
    function automatic void absorb_item(input hdr_item_t it, output bit got, output verdict_t v);
        int p;
        got = 1'b0;
        v   = '0;
        if (it.op == OP_TPL_WRITE) begin
            tpl_shadow[it.position] = it.data_byte;
            return;
        end
        p = frame_ofs;
        if (!byte_passes(p, it.data_byte)) frame_bad = 1'b1;
        if (frame_ofs < int'(POS_MAX)) frame_ofs++;
        if (it.last == 1'b0) begin
            return;
        end
        if (p < last_needed_ofs()) begin
            v = '{matched: 1'b0, frame_short: 1'b1};
        end else begin
            v = '{matched: !frame_bad, frame_short: 1'b0};
        end
        frame_ofs = 0;
        frame_bad = 1'b0;
        got       = 1'b1;
    endfunction

    // A byte value that passes at offset p, with random content where allowed.
    function automatic logic [7:0] good_byte(input int p);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (p == 0 && shadow_cfg.match_mode == MODE_ETH_MCAST) c[0] = 1'b1;
        if (!byte_passes(p, c)) c = tpl_byte(p) | (c & 8'hF0);
        if (!byte_passes(p, c)) c = tpl_byte(p);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offers one item, idling first at random, and waits for its handshake.
    // The item is folded into the shadow at the edge that accepts it.
    task automatic send_item(input hdr_item_t it, input bit typed, input verdict_t want);
        bit       got;
        verdict_t v;
        if ($urandom_range(0, 99) < send_idle) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        item_ch.valid     <= 1'b1;
        item_ch.op        <= it.op;
        item_ch.position  <= it.position;
        item_ch.data_byte <= it.data_byte;
        item_ch.last      <= it.last;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        absorb_item(it, got, v);
        if (got) begin
            pending_verdicts.push_back(typed ? want : v);
            frames_done++;
        end
        items_sent++;
    endtask

    // Stops offering items until every verdict is in and the pipeline is empty.
    task automatic park_sender();
        item_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_index idx, input logic [HMT_CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MATCH_MODE: shadow_cfg.match_mode      = val[2:0];
            CFG_L2_LENGTH:  shadow_cfg.l2_length       = val[4:0];
            CFG_UDP_OFFSET: shadow_cfg.udp_offset      = val;
            CFG_L3_OFFSET:  shadow_cfg.l3_match_offset = val;
            CFG_L3_LENGTH:  shadow_cfg.l3_match_length = val;
            default: ;
        endcase
    endtask

    // Registers are only touched with the block idle.
    task automatic configure(input t_hmt_cfg c);
        park_sender();
        put_reg(CFG_MATCH_MODE, 7'(c.match_mode));
        put_reg(CFG_L2_LENGTH, 7'(c.l2_length));
        put_reg(CFG_UDP_OFFSET, c.udp_offset);
        put_reg(CFG_L3_OFFSET, c.l3_match_offset);
        put_reg(CFG_L3_LENGTH, c.l3_match_length);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tpl_write(input logic [6:0] pos, input logic [7:0] data);
        send_item('{op: OP_TPL_WRITE, position: pos, data_byte: data, last: 1'b0}, 1'b0, '0);
    endtask

    // One random frame. Most frames are long enough and follow the template,
    // some carry one wrong byte, some stop short, and a few are pure noise or
    // run past the saturation point of the frame offset.
    task automatic send_frame();
        int         req;
        int         len;
        int         bad_at;
        int         k;
        bit         noisy;
        logic [7:0] b;
        req   = last_needed_ofs();
        k     = $urandom_range(0, 99);
        noisy = 1'b0;
        if (k < 60) begin
            len = ((req < 0) ? 1 : req + 1) + $urandom_range(0, 6);
        end else if (k < 75) begin
            len = (req >= 1) ? $urandom_range(1, req) : $urandom_range(1, 5);
        end else if (k < 82) begin
            // Right at the boundary between short and complete.
            len = ((req < 1) ? 1 : req) + $urandom_range(0, 1);
        end else if (k < 84 && long_frames < 4) begin
            len = $urandom_range(256, 300);
            long_frames++;
        end else begin
            len   = $urandom_range(1, 40);
            noisy = 1'b1;
        end
        bad_at = ($urandom_range(0, 99) < 35) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            // Template updates may land in the middle of a frame.
            if ($urandom_range(0, 99) < 3) begin
                send_tpl_write(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
            end
            if (noisy || i == bad_at) begin
                b = 8'($urandom_range(0, 255));
            end else begin
                b = good_byte(frame_ofs);
            end
            send_item('{op: OP_FRAME_BYTE, position: 7'($urandom_range(0, 127)),
                        data_byte: b, last: (i == len - 1)}, 1'b0, '0);
        end
    endtask

    function automatic row_t cfg_row(input logic [2:0] mode, input logic [4:0] l2,
                                     input logic [6:0] u, input logic [6:0] lo,
                                     input logic [6:0] ln);
        row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.cfg   = '{match_mode: mode, l2_length: l2, udp_offset: u,
                    l3_match_offset: lo, l3_match_length: ln};
        return r;
    endfunction

    function automatic row_t item_row(input logic op, input logic [6:0] pos,
                                      input logic [7:0] data, input logic last,
                                      input logic typed, input logic matched,
                                      input logic short_seen);
        row_t r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.item  = '{op: op, position: pos, data_byte: data, last: last};
        r.typed = typed;
        r.want  = '{matched: matched, frame_short: short_seen};
        return r;
    endfunction

    // Random register settings for one phase, mostly small offsets so that
    // frames stay short, with the occasional wide setting.
    function automatic t_hmt_cfg random_cfg();
        t_hmt_cfg c;
        int       k;
        c.match_mode = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
        k = $urandom_range(0, 9);
        c.l2_length = (k < 5) ? VLAN_L2_LENGTH :
                      (k < 9) ? ETH_L2_LENGTH : 5'($urandom_range(15, 17));
        c.udp_offset      = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(0, 24));
        c.l3_match_offset = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                        : 7'($urandom_range(0, 30));
        k = $urandom_range(0, 19);
        c.l3_match_length = (k == 0) ? 7'd64 :
                            (k < 4)  ? 7'($urandom_range(0, 64)) : 7'($urandom_range(0, 16));
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("verdict arrived with none pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (result_ch.matched !== want.matched) begin
                    report_mismatch($sformatf("matched is %b, wanted %b",
                                              result_ch.matched, want.matched));
                end
                if (result_ch.frame_short !== want.frame_short) begin
                    report_mismatch($sformatf("frame_short is %b, wanted %b",
                                              result_ch.frame_short, want.frame_short));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin
        t_hmt_cfg c;
        error_count = 0;
        items_sent  = 0;
        frames_done = 0;
        long_frames = 0;
        send_idle   = 0;
        recv_idle   = 0;
        frame_ofs   = 0;
        frame_bad   = 1'b0;
        shadow_cfg  = '{match_mode: MODE_ALWAYS, l2_length: ETH_L2_LENGTH, udp_offset: 7'd0,
                        l3_match_offset: 7'd0, l3_match_length: 7'd0};

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MATCH_MODE;
        cfg_data          <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.op        <= OP_TPL_WRITE;
        item_ch.position  <= '0;
        item_ch.data_byte <= '0;
        item_ch.last      <= 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The template is never cleared by reset, so it is filled in full
        // before the first frame byte reads it.
        for (int p = 0; p < HMT_TEMPLATE_BYTES; p++) begin
            send_tpl_write(7'(p), 8'($urandom_range(0, 255)));
        end

        // Directed table. Typed verdicts are the ones obvious from the rules:
        // always mode and the undefined modes match, frames that stop before
        // the last needed byte are short, and a wrong first byte in unicast
        // mode fails.
        directed_rows.push_back(cfg_row(MODE_ALWAYS, ETH_L2_LENGTH, 7'd0, 7'd0, 7'd0));
        directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd127, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(cfg_row(MODE_UNDEF_HI, ETH_L2_LENGTH, 7'd0, 7'd0, 7'd0));
        directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(cfg_row(MODE_UNDEF_LO, ETH_L2_LENGTH, 7'd0, 7'd0, 7'd0));
        directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd64, 8'hA5, 1'b1, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(cfg_row(MODE_VXLAN, VLAN_L2_LENGTH, 7'd127, 7'd127, 7'd64));
        directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1));
        directed_rows.push_back(item_row(OP_TPL_WRITE, 7'd127, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(item_row(OP_TPL_WRITE, 7'd0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(cfg_row(MODE_ETH_UCAST, ETH_L2_LENGTH, 7'd0, 7'd0, 7'd0));
        directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd0, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b1));
        // A complete unicast header of all ones against a zero first template
        // byte, with a template write slipped in mid-frame.
        for (int i = 0; i < 14; i++) begin
            if (i == 4) begin
                directed_rows.push_back(item_row(OP_TPL_WRITE, 7'd5, 8'h00, 1'b0,
                                                 1'b0, 1'b0, 1'b0));
            end
            directed_rows.push_back(item_row(OP_FRAME_BYTE, 7'd0, 8'hFF, (i == 13),
                                             (i == 13), 1'b0, 1'b0));
        end

        send_idle = 34;
        recv_idle = 79;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                configure(directed_rows[i].cfg);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases: new register settings, a little template preparation
        // so that masked bytes can match, then a run of frames.
        items_sent  = 0;
        frames_done = 0;
        while (items_sent < RANDOM_ITEMS || frames_done < RANDOM_FRAMES) begin
            if (items_sent < RANDOM_ITEMS / 3) begin
                send_idle = 34;
                recv_idle = 79;
            end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle = 79;
                recv_idle = 34;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (items_sent == 0) begin
                // The widest setting of every register that random_cfg draws comes first.
                c = '{match_mode: MODE_VXLAN, l2_length: VLAN_L2_LENGTH, udp_offset: 7'd127,
                      l3_match_offset: 7'd127, l3_match_length: 7'd64};
            end else begin
                c = random_cfg();
            end
            configure(c);
            if (c.l2_length == VLAN_L2_LENGTH && $urandom_range(0, 99) < 80) begin
                send_tpl_write(7'd14, 8'($urandom_range(0, 255)) & VID_HI_MASK);
            end
            if (c.match_mode == MODE_VXLAN && int'(c.udp_offset) + 15 < HMT_TEMPLATE_BYTES &&
                $urandom_range(0, 99) < 80) begin
                send_tpl_write(7'(int'(c.udp_offset) + 15), 8'h00);
            end
            for (int n = items_sent + PHASE_ITEMS; items_sent < n;) begin
                send_frame();
                if ($urandom_range(0, 49) == 0) begin
                    park_sender();
                end
                if (items_sent >= RANDOM_ITEMS && frames_done >= RANDOM_FRAMES) break;
            end
        end

        park_sender();
        if (error_count == 0) begin
            $display("rx_header_template_matcher_test: PASS");
        end else begin
            $display("rx_header_template_matcher_test: FAIL");
        end
        $finish;
    end

endmodule
